// ===== rtl/core/qwt_pkg.sv =====
// Shared types and character constants of the quoted word tokenizer.
package qwt_pkg;

	localparam int unsigned QueueDepth = 4;

	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChSquote    = 8'h27;
	localparam logic [7:0] ChDquote    = 8'h22;
	localparam logic [7:0] ChSpace     = 8'h20;
	localparam logic [7:0] ChTab       = 8'h09;
	localparam logic [7:0] ChLf        = 8'h0A;
	localparam logic [7:0] ChCr        = 8'h0D;
	localparam logic [7:0] ChLowerN    = 8'h6E;
	localparam logic [7:0] ChLowerR    = 8'h72;
	localparam logic [7:0] ChLowerT    = 8'h74;

	// One result word as it leaves the block, without its last flag.
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       word_end;
		logic       line_done;
	} res_t;

	// Everything one input byte produces: up to three result words.
	typedef struct packed {
		logic [1:0]       cnt;
		res_t [2:0]       res;
	} plan_t;

endpackage

// ===== rtl/core/qwt_in_if.sv =====
// Input channel of the tokenizer: one raw byte and its end-of-line flag.
interface qwt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       line_last;

	modport source (output valid, output in_char, output line_last, input ready);
	modport sink (input valid, input in_char, input line_last, output ready);
endinterface

// ===== rtl/core/qwt_out_if.sv =====
// Output channel of the tokenizer: one word character or marker per word.
interface qwt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       word_end;
	logic       line_done;
	logic       last;

	modport source (output valid, output out_char, output char_valid, output word_end,
		output line_done, output last, input ready);
	modport sink (input valid, input out_char, input char_valid, input word_end,
		input line_done, input last, output ready);
endinterface

// ===== rtl/core/qwt_front.sv =====
// Front end: classifies each byte, keeps the quoting state and builds its result plan.
module qwt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    in_char,
	input  logic          line_last,
	output qwt_pkg::plan_t plan,
	output logic          plan_valid
);
	import qwt_pkg::*;

	logic quoting_q, dquote_q, esc_q, word_open_q;
	logic quoting_d, dquote_d, esc_d, word_open_d;
	logic [1:0] n_ch;
	logic [7:0] ch0, ch1;
	logic       sp_end;
	logic [1:0] n_body;
	logic       wo_body;

	always_comb begin
		quoting_d = quoting_q;
		dquote_d  = dquote_q;
		esc_d     = esc_q;
		n_ch      = 2'd0;
		ch0       = in_char;
		ch1       = in_char;
		sp_end    = 1'b0;
		if (quoting_q) begin
			if (esc_q) begin
				esc_d = 1'b0;
				n_ch  = 2'd1;
				case (in_char)
					ChLowerN: ch0 = ChLf;
					ChLowerR: ch0 = ChCr;
					ChLowerT: ch0 = ChTab;
					ChBackslash, ChSquote, ChDquote: ch0 = in_char;
					default: begin
						// Unknown escape keeps the backslash in front of the byte.
						ch0  = ChBackslash;
						n_ch = 2'd2;
					end
				endcase
			end else if (in_char == (dquote_q ? ChDquote : ChSquote)) begin
				quoting_d = 1'b0;
				dquote_d  = 1'b0;
			end else if (in_char == ChBackslash) begin
				esc_d = 1'b1;
			end else begin
				n_ch = 2'd1;
			end
		end else begin
			if (in_char == ChSquote || in_char == ChDquote) begin
				quoting_d = 1'b1;
				dquote_d  = (in_char == ChDquote);
			end else if (in_char == ChSpace) begin
				sp_end = word_open_q;
			end else if (in_char == ChTab || in_char == ChCr || in_char == ChLf) begin
				n_ch = 2'd0;
			end else begin
				n_ch = 2'd1;
			end
		end
	end

	assign n_body  = sp_end ? 2'd1 : n_ch;
	assign wo_body = (n_ch != 2'd0) ? 1'b1 : (sp_end ? 1'b0 : word_open_q);

	always_comb begin
		plan = '0;
		if (sp_end) begin
			plan.res[0].word_end = 1'b1;
		end else begin
			if (n_ch != 2'd0) begin
				plan.res[0].out_char   = ch0;
				plan.res[0].char_valid = 1'b1;
			end
			if (n_ch == 2'd2) begin
				plan.res[1].out_char   = ch1;
				plan.res[1].char_valid = 1'b1;
			end
		end
		if (line_last) begin
			plan.res[n_body].word_end  = wo_body;
			plan.res[n_body].line_done = 1'b1;
		end
		plan.cnt = n_body + {1'b0, line_last};
	end

	assign plan_valid = take && (plan.cnt != 2'd0);
	assign word_open_d = wo_body;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quoting_q   <= 1'b0;
			dquote_q    <= 1'b0;
			esc_q       <= 1'b0;
			word_open_q <= 1'b0;
		end else if (take) begin
			if (line_last) begin
				quoting_q   <= 1'b0;
				dquote_q    <= 1'b0;
				esc_q       <= 1'b0;
				word_open_q <= 1'b0;
			end else begin
				quoting_q   <= quoting_d;
				dquote_q    <= dquote_d;
				esc_q       <= esc_d;
				word_open_q <= word_open_d;
			end
		end
	end

endmodule

// ===== rtl/core/qwt_queue.sv =====
// Small register queue of result plans between the front and back ends.
module qwt_queue #(
	parameter int unsigned Depth = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  qwt_pkg::plan_t push_data,
	input  logic           pop,
	output qwt_pkg::plan_t head,
	output logic           not_empty,
	output logic           not_full
);
	import qwt_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	plan_t         mem_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;

	assign not_empty = (cnt_q != '0);
	assign not_full  = (cnt_q != CntW'(Depth));
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/qwt_back.sv =====
// Back end: steps through the result words of the plan at the queue head.
module qwt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  qwt_pkg::plan_t head,
	input  logic           head_valid,
	output logic           pop,
	qwt_out_if.source      out_w
);
	import qwt_pkg::*;

	logic [1:0] idx_q;
	logic       is_last;
	res_t       cur;

	assign cur     = head.res[idx_q];
	assign is_last = (idx_q == head.cnt - 2'd1);

	assign out_w.valid      = head_valid;
	assign out_w.out_char   = cur.out_char;
	assign out_w.char_valid = cur.char_valid;
	assign out_w.word_end   = cur.word_end;
	assign out_w.line_done  = cur.line_done;
	assign out_w.last       = is_last;

	assign pop = head_valid && out_w.ready && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (head_valid && out_w.ready) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ===== rtl/core/quoted_word_tokenizer.sv =====
// Top level of the quoted word tokenizer: front end, plan queue and back end.
//
//   channel | role  | word carries
//   --------+-------+---------------------------------------------------------
//   in_w    | sink  | in_char, line_last: one raw byte of the line
//   out_w   | source| out_char, char_valid, word_end, line_done, last
//
// A byte is taken whenever the plan queue has room; the front end updates the
// quoting state in that same cycle, so bytes stream at one per cycle.
// Each byte that yields output leaves one to three words; the back end sends one
// word per cycle from the queue head while out_w is ready; a byte with two or
// three words (unknown escapes, line ends) is popped with its last word.
// Reset clears the quoting state, the queue pointers and the word index.
// A stalled output fills the queue (QueueDepth plans) before input is held off;
// bytes that give no words never enter the queue.
module quoted_word_tokenizer #(
	parameter int unsigned QueueDepth = qwt_pkg::QueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	qwt_in_if.sink    in_w,
	qwt_out_if.source out_w
);
	import qwt_pkg::*;

	plan_t plan, head;
	logic  plan_valid, head_valid, not_full, pop, take;

	// The input is held off only when the queue is full.
	assign in_w.ready = not_full;
	assign take       = in_w.valid && not_full;

	qwt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.in_char    (in_w.in_char),
		.line_last  (in_w.line_last),
		.plan       (plan),
		.plan_valid (plan_valid)
	);

	qwt_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (plan_valid),
		.push_data (plan),
		.pop       (pop),
		.head      (head),
		.not_empty (head_valid),
		.not_full  (not_full)
	);

	qwt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_w      (out_w)
	);

endmodule

// ===== rtl/core/qwt_checker.sv =====
// Port-level checks of the tokenizer output, bound to the top level.
module qwt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       char_valid,
	input logic       word_end,
	input logic       line_done,
	input logic       last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
		else $error("output word changed while stalled");

	a_char_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> !word_end && !line_done)
		else $error("character word also carries a marker");

	a_line_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> last && !char_valid)
		else $error("line end word is not the final word of its byte");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> out_char == 8'd0 && (word_end || line_done))
		else $error("marker word has a character or no marker");

endmodule

bind quoted_word_tokenizer qwt_checker u_qwt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_w.valid),
	.out_ready  (out_w.ready),
	.out_char   (out_w.out_char),
	.char_valid (out_w.char_valid),
	.word_end   (out_w.word_end),
	.line_done  (out_w.line_done),
	.last       (out_w.last)
);
